FILE: rtl/core/kirsch_edge_threshold_unit_defines.svh
// assertion macros shared by the kirsch edge threshold rtl
`ifndef KIRSCH_EDGE_THRESHOLD_UNIT_DEFINES_SVH
`define KIRSCH_EDGE_THRESHOLD_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk and held off while rst_n is low
`define KET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and held off while rst_n is low
`define KET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ket_pkg.sv
// shared constants and types of the kirsch edge threshold unit
`default_nettype none

package ket_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned MIN_WIDTH       = 3;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned LW_W       = 11;
  localparam int unsigned STR_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned OUT_DATA_W = 16;

  // sum of eight pixels, sum of three pixels, signed kernel response
  localparam int unsigned SUM_W = 11;
  localparam int unsigned NEG_W = 10;
  localparam int unsigned KRN_W = 14;

  localparam logic [THR_W-1:0] THR_RESET = 12'd200;
  localparam logic [LW_W-1:0]  LW_RESET  = 11'd640;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LW  = 1'b1;

  localparam logic [1:0] ROWS_FULL = 2'd2;

  // 3x3 neighborhood of one pixel that yields a result, centre left out
  typedef struct packed {
    logic             vld;
    logic             row_end;
    logic [PIX_W-1:0] p1;
    logic [PIX_W-1:0] p2;
    logic [PIX_W-1:0] p3;
    logic [PIX_W-1:0] p4;
    logic [PIX_W-1:0] p6;
    logic [PIX_W-1:0] p7;
    logic [PIX_W-1:0] p8;
    logic [PIX_W-1:0] p9;
  } win_t;

  typedef struct packed {
    logic             edge_res;
    logic [STR_W-1:0] strength;
    logic             row_end;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/kirsch_edge_threshold_unit.sv
// top level of the kirsch compass edge detector with threshold
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready | tdata[7:0] pixel, tuser frame_start
//  out_    | out | out_tvalid/out_tready | tdata[11:0] strength, tuser edge_res,
//          |     |                       | tlast row_end
//  cfg_    | in  | cfg_we                | index 0 edge_threshold, 1 line_width
//
// one pixel per clock while in_tready is high; a result reaches out_tvalid through the sums,
// absolute responses, maximum and queue write registers after the edge that takes its pixel
// (the line store read shares the taking edge).
// in_tready drops only when the result queue plus the window and the kernel stages hold
// QUEUE_DEPTH results, so a stalled output holds up the input after that many words.
// rst_n is synchronous; the line stores need no clearing, the block is ready at once.
`default_nettype none

module kirsch_edge_threshold_unit #(
  parameter int unsigned MAX_WIDTH   = ket_pkg::MAX_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = ket_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ket_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel
  input  wire logic                            in_tuser,   // [0] frame_start

  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ket_pkg::OUT_DATA_W-1:0]       out_tdata,  // [11:0] strength, rest zero
  output logic                                 out_tuser,  // [0] edge_res
  output logic                                 out_tlast,

  input  wire logic                            cfg_we,
  input  wire logic [ket_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ket_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCW = CW + 1;

  logic [ket_pkg::THR_W-1:0] thr_r;
  logic [ket_pkg::LW_W-1:0]  lw_r;

  logic          in_acc;
  logic          out_acc;
  ket_pkg::win_t win;
  ket_pkg::res_t res;
  logic          res_vld;
  logic [2:0]    busy;
  ket_pkg::res_t q_dout;
  logic [CW-1:0] q_count;
  logic [OCW-1:0] occ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ket_pkg::THR_RESET;
      lw_r  <= ket_pkg::LW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ket_pkg::CFG_IDX_THR: thr_r <= cfg_wdata[ket_pkg::THR_W-1:0];
        ket_pkg::CFG_IDX_LW:  lw_r  <= cfg_wdata[ket_pkg::LW_W-1:0];
      endcase
    end
  end

  // results already owed, queued or still in the kernel stages
  assign occ       = OCW'(q_count) + OCW'(busy);
  assign in_tready = occ < OCW'(QUEUE_DEPTH);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  ket_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .pix         (in_tdata),
    .frame_start (in_tuser),
    .line_width  (lw_r),
    .win         (win)
  );

  ket_kernel u_kernel (
    .clk     (clk),
    .rst_n   (rst_n),
    .win     (win),
    .thr     (thr_r),
    .res     (res),
    .res_vld (res_vld),
    .busy    (busy)
  );

  ket_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld),
    .din   (res),
    .pop   (out_acc),
    .dout  (q_dout),
    .vld   (out_tvalid),
    .count (q_count)
  );

  assign out_tdata = ket_pkg::OUT_DATA_W'(q_dout.strength);
  assign out_tuser = q_dout.edge_res;
  assign out_tlast = q_dout.row_end;

endmodule

`default_nettype wire

FILE: rtl/core/ket_ram.sv
// generic single-write, registered-read ram
`default_nettype none

module ket_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 1024,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when both ports hit the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ket_front.sv
// front end: row and column tracking, line stores and the 3x3 window
`default_nettype none
`include "kirsch_edge_threshold_unit_defines.svh"

module ket_front #(
  parameter int unsigned MAX_WIDTH = ket_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc,
  input  wire logic [ket_pkg::PIX_W-1:0]  pix,
  input  wire logic                       frame_start,
  input  wire logic [ket_pkg::LW_W-1:0]   line_width,
  output ket_pkg::win_t                   win
);

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (WW > ket_pkg::LW_W) ? WW : ket_pkg::LW_W;

  logic [CMP_W-1:0] lw_x;
  logic [CMP_W-1:0] w_x;

  logic [AW-1:0] cnt_r;
  logic [AW-1:0] cnt_nxt;
  logic [1:0]    rows_r;
  logic [1:0]    rows_nxt;

  logic [AW-1:0]    cnt0;
  logic [1:0]       rows0;
  logic [1:0]       rows1;
  logic [AW-1:0]    col;
  logic [CMP_W-1:0] col_inc;
  logic             wrap0;
  logic             wrap1;
  logic             prod0;
  logic             rend0;

  logic                      s1_v_r;
  logic                      s1_prod_r;
  logic                      s1_rend_r;
  logic                      s1_byp_r;
  logic [AW-1:0]             s1_col_r;
  logic [ket_pkg::PIX_W-1:0] s1_pix_r;
  logic [ket_pkg::PIX_W-1:0] prev_mid_r;
  logic [ket_pkg::PIX_W-1:0] prev_pix_r;

  logic [ket_pkg::PIX_W-1:0] rd_a;
  logic [ket_pkg::PIX_W-1:0] rd_b;
  logic [ket_pkg::PIX_W-1:0] top;
  logic [ket_pkg::PIX_W-1:0] mid;

  logic [ket_pkg::PIX_W-1:0] win_r [6];

  // clamp the programmed width into the legal range
  always_comb begin
    lw_x = CMP_W'(line_width);
    priority if (lw_x < CMP_W'(ket_pkg::MIN_WIDTH)) begin
      w_x = CMP_W'(ket_pkg::MIN_WIDTH);
    end else if (lw_x > CMP_W'(MAX_WIDTH)) begin
      w_x = CMP_W'(MAX_WIDTH);
    end else begin
      w_x = lw_x;
    end
  end

  always_comb begin
    cnt0    = frame_start ? '0 : cnt_r;
    rows0   = frame_start ? '0 : rows_r;
    // a width shrunk mid-row ends the row before the word is placed
    wrap0   = CMP_W'(cnt0) >= w_x;
    col     = wrap0 ? '0 : cnt0;
    rows1   = (wrap0 && (rows0 != ket_pkg::ROWS_FULL)) ? rows0 + 2'd1 : rows0;
    col_inc = CMP_W'(col) + CMP_W'(1);
    wrap1   = col_inc >= w_x;
    prod0   = (rows1 == ket_pkg::ROWS_FULL) && (col >= AW'(2));
    rend0   = CMP_W'(col) == (w_x - CMP_W'(1));
    cnt_nxt  = cnt_r;
    rows_nxt = rows_r;
    if (acc) begin
      cnt_nxt  = wrap1 ? '0 : col_inc[AW-1:0];
      rows_nxt = (wrap1 && (rows1 != ket_pkg::ROWS_FULL)) ? rows1 + 2'd1 : rows1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rows_r    <= '0;
      s1_v_r    <= 1'b0;
      s1_prod_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      rows_r    <= rows_nxt;
      s1_v_r    <= acc;
      s1_prod_r <= acc && prod0;
    end
  end

  always_ff @(posedge clk) begin
    s1_rend_r <= rend0;
    s1_col_r  <= col;
    s1_pix_r  <= pix;
    // the read of this word raced the write of the word before it
    s1_byp_r  <= s1_v_r && (col == s1_col_r);
    if (s1_v_r) begin
      prev_mid_r <= mid;
      prev_pix_r <= s1_pix_r;
    end
  end

  ket_ram #(
    .WIDTH (ket_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .raddr (col),
    .rdata (rd_a)
  );

  ket_ram #(
    .WIDTH (ket_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (s1_col_r),
    .wdata (mid),
    .raddr (col),
    .rdata (rd_b)
  );

  assign top = s1_byp_r ? prev_mid_r : rd_b;
  assign mid = s1_byp_r ? prev_pix_r : rd_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  always_comb begin
    win.vld     = s1_v_r && s1_prod_r;
    win.row_end = s1_rend_r;
    win.p1      = win_r[0];
    win.p4      = win_r[1];
    win.p7      = win_r[2];
    win.p2      = win_r[3];
    win.p8      = win_r[5];
    win.p3      = top;
    win.p6      = mid;
    win.p9      = s1_pix_r;
  end

  `KET_ASSERT_NEXT(a_col_in_row, acc, CMP_W'(cnt_r) < $past(w_x), "column count past row end")
  `KET_ASSERT_NOW(a_byp_same_col, s1_byp_r, $past(s1_col_r) == s1_col_r, "bypass on other column")

endmodule

`default_nettype wire

FILE: rtl/core/ket_kernel.sv
// compass kernel pipeline: sums, absolute responses, maximum and threshold
`default_nettype none
`include "kirsch_edge_threshold_unit_defines.svh"

module ket_kernel (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ket_pkg::win_t              win,
  input  wire logic [ket_pkg::THR_W-1:0]  thr,
  output ket_pkg::res_t                   res,
  output logic                            res_vld,
  output logic [2:0]                      busy
);

  localparam int unsigned SW = ket_pkg::SUM_W;
  localparam int unsigned NW = ket_pkg::NEG_W;
  localparam int unsigned KW = ket_pkg::KRN_W;
  localparam int unsigned RW = ket_pkg::STR_W;

  // each kernel is three times the ring sum less eight times its negative taps
  function automatic logic [RW-1:0] resp_abs(input logic [SW-1:0] t,
                                              input logic [NW-1:0] n);
    logic [KW-1:0] t3;
    logic [KW-1:0] d;
    t3 = (KW'(t) << 1) + KW'(t);
    d  = t3 - (KW'(n) << 3);
    if (d[KW-1]) begin
      d = -d;
    end
    return d[RW-1:0];
  endfunction

  logic          a_v_r;
  logic          a_re_r;
  logic [SW-1:0] t_r;
  logic [NW-1:0] na_r;
  logic [NW-1:0] nb_r;
  logic [NW-1:0] nc_r;
  logic [NW-1:0] nd_r;

  logic          b_v_r;
  logic          b_re_r;
  logic [RW-1:0] ka_r;
  logic [RW-1:0] kb_r;
  logic [RW-1:0] kc_r;
  logic [RW-1:0] kd_r;

  logic          c_v_r;
  ket_pkg::res_t res_r;

  logic [RW-1:0] m_ab;
  logic [RW-1:0] m_cd;
  logic [RW-1:0] m_all;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= win.vld;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_re_r <= win.row_end;
    t_r    <= SW'(win.p1) + SW'(win.p2) + SW'(win.p3) + SW'(win.p4)
            + SW'(win.p6) + SW'(win.p7) + SW'(win.p8) + SW'(win.p9);
    na_r   <= NW'(win.p1) + NW'(win.p2) + NW'(win.p3);
    nb_r   <= NW'(win.p2) + NW'(win.p3) + NW'(win.p6);
    nc_r   <= NW'(win.p3) + NW'(win.p6) + NW'(win.p9);
    nd_r   <= NW'(win.p6) + NW'(win.p8) + NW'(win.p9);

    b_re_r <= a_re_r;
    ka_r   <= resp_abs(t_r, na_r);
    kb_r   <= resp_abs(t_r, nb_r);
    kc_r   <= resp_abs(t_r, nc_r);
    kd_r   <= resp_abs(t_r, nd_r);

    res_r.row_end  <= b_re_r;
    res_r.strength <= m_all;
    res_r.edge_res <= m_all > thr;
  end

  always_comb begin
    m_ab  = (kb_r > ka_r) ? kb_r : ka_r;
    m_cd  = (kd_r > kc_r) ? kd_r : kc_r;
    m_all = (m_cd > m_ab) ? m_cd : m_ab;
  end

  assign res     = res_r;
  assign res_vld = c_v_r;
  assign busy    = 3'($countones({win.vld, a_v_r, b_v_r, c_v_r}));

  `KET_ASSERT_NOW(a_flag_match, c_v_r, res_r.edge_res == (res_r.strength > thr), "flag vs strength")

endmodule

`default_nettype wire

FILE: rtl/core/ket_queue.sv
// result queue between the kernel pipeline and the output channel
`default_nettype none
`include "kirsch_edge_threshold_unit_defines.svh"

module ket_queue #(
  parameter  int unsigned DEPTH = ket_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ket_pkg::res_t din,
  input  wire logic          pop,
  output ket_pkg::res_t      dout,
  output logic               vld,
  output logic [CW-1:0]      count
);

  ket_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign vld   = count_r != '0;
  assign count = count_r;

  `KET_ASSERT_NOW(a_no_overflow, push && !pop, count_r != CW'(DEPTH), "queue overflow")
  `KET_ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + CW'(1), "count lost a word")

endmodule

`default_nettype wire
